// ----- rtl/gdad_pkg.sv -----
// shared types, constants and calendar helpers for the date adder
package gdad_pkg;

  localparam int STEP_W       = 3;
  localparam int REDUCE_STEPS = 6;
  // largest multiple of 400 used in the year mod 400 reduction, halved each step
  localparam logic [13:0] REDUCE_TOP   = 14'd12800;
  localparam logic [15:0] DAYS_LEAP    = 16'd366;
  localparam logic [15:0] DAYS_COMMON  = 16'd365;
  localparam logic [8:0]  CYCLE_LAST   = 9'd399;
  localparam logic [3:0]  MONTH_FIRST  = 4'd1;
  localparam logic [3:0]  MONTH_FEB    = 4'd2;
  localparam logic [3:0]  MONTH_MAR    = 4'd3;
  localparam logic [3:0]  MONTH_LAST   = 4'd12;
  localparam logic [4:0]  DAY_FIRST    = 5'd1;
  localparam logic [4:0]  DAY_LEAP     = 5'd29;

  typedef enum logic [2:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_REDUCE,
    CMD_CLAMP,
    CMD_YEAR,
    CMD_DAY,
    CMD_OUT
  } gdad_op_t;

  typedef struct packed {
    gdad_op_t          op;
    logic [STEP_W-1:0] step;
  } gdad_cmd_t;

  typedef struct packed {
    logic n_ge_year;
    logic n_zero;
  } gdad_status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CLAMP,
    ST_YEAR,
    ST_DAY,
    ST_DONE
  } gdad_state_t;

  // leap test on the year taken mod 400
  function automatic logic is_leap(input logic [8:0] r);
    is_leap = (r == 9'd0) ||
              ((r[1:0] == 2'd0) && (r != 9'd100) && (r != 9'd200) && (r != 9'd300));
  endfunction

  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    case (m)
      4'd2:                    month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                 month_len = 5'd31;
    endcase
  endfunction

  function automatic logic [13:0] reduce_const(input logic [STEP_W-1:0] step);
    reduce_const = REDUCE_TOP >> step;
  endfunction

endpackage

// ----- rtl/gregorian_date_add_days.sv -----
// year jumps run one per cycle while 366 or more days remain, then one day per cycle
// one item at a time
// the next item is taken while a result waits in the output register
// the year mod 400 is found by compare-subtract steps after accept
// rst is synchronous, active high, and returns the sequencer to idle with no result held
// top level of the gregorian date adder
module gregorian_date_add_days (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [4:0]  start_day,
  input  logic [3:0]  start_month,
  input  logic [13:0] start_year,
  input  logic [15:0] days_to_add,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [4:0]  end_day,
  output logic [3:0]  end_month,
  output logic [13:0] end_year
);
  import gdad_pkg::*;

  gdad_cmd_t    cmd;
  gdad_status_t status;

  gdad_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  gdad_datapath u_dp (
    .clk         (clk),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .days_to_add (days_to_add),
    .cmd         (cmd),
    .status      (status),
    .end_day     (end_day),
    .end_month   (end_month),
    .end_year    (end_year)
  );

endmodule

// ----- rtl/gdad_datapath.sv -----
// date registers, year mod 400 tracking and the day count for the date adder
module gdad_datapath (
  input  logic                  clk,
  input  logic [4:0]            start_day,
  input  logic [3:0]            start_month,
  input  logic [13:0]           start_year,
  input  logic [15:0]           days_to_add,
  input  gdad_pkg::gdad_cmd_t   cmd,
  output gdad_pkg::gdad_status_t status,
  output logic [4:0]            end_day,
  output logic [3:0]            end_month,
  output logic [13:0]           end_year
);
  import gdad_pkg::*;

  logic [4:0]  d;
  logic [3:0]  m;
  logic [13:0] y;
  logic [13:0] r;
  logic [15:0] n;

  logic [8:0]  r_cur;
  logic [8:0]  r_inc;
  logic        leap_cur;
  logic        leap_inc;
  logic [4:0]  len;
  logic [13:0] sub;

  assign r_cur    = r[8:0];
  assign r_inc    = (r_cur == CYCLE_LAST) ? 9'd0 : r_cur + 9'd1;
  assign leap_cur = is_leap(r_cur);
  assign leap_inc = is_leap(r_inc);
  assign len      = month_len(m, leap_cur);
  assign sub      = reduce_const(cmd.step);

  assign status.n_ge_year = (n >= DAYS_LEAP);
  assign status.n_zero    = (n == 16'd0);

  always_ff @(posedge clk) begin
    case (cmd.op)
      CMD_LOAD: begin
        d <= (start_day == 5'd0) ? DAY_FIRST : start_day;
        if (start_month == 4'd0) begin
          m <= MONTH_FIRST;
        end else if (start_month > MONTH_LAST) begin
          m <= MONTH_LAST;
        end else begin
          m <= start_month;
        end
        y <= start_year;
        r <= start_year;
        n <= days_to_add;
      end
      CMD_REDUCE: begin
        if (r >= sub) begin
          r <= r - sub;
        end
      end
      CMD_CLAMP: begin
        if (d > len) begin
          d <= len;
        end
      end
      CMD_YEAR: begin
        // whole year jump, feb 29 start lands on mar 1
        if (m <= MONTH_FEB) begin
          if (leap_cur) begin
            n <= n - DAYS_LEAP;
            if ((m == MONTH_FEB) && (d == DAY_LEAP)) begin
              m <= MONTH_MAR;
              d <= DAY_FIRST;
            end
          end else begin
            n <= n - DAYS_COMMON;
          end
        end else begin
          n <= n - (leap_inc ? DAYS_LEAP : DAYS_COMMON);
        end
        y <= y + 14'd1;
        r <= {5'd0, r_inc};
      end
      CMD_DAY: begin
        n <= n - 16'd1;
        if (d >= len) begin
          d <= DAY_FIRST;
          if (m == MONTH_LAST) begin
            m <= MONTH_FIRST;
            y <= y + 14'd1;
            r <= {5'd0, r_inc};
          end else begin
            m <= m + 4'd1;
          end
        end else begin
          d <= d + 5'd1;
        end
      end
      CMD_OUT: begin
        end_day   <= d;
        end_month <= m;
        end_year  <= y;
      end
      default: begin
      end
    endcase
  end

endmodule

// ----- rtl/gdad_ctrl.sv -----
// sequencer for the date adder: load, year mod 400, clamp, year jumps, day steps, output
module gdad_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  output logic                   out_valid,
  input  logic                   out_stall,
  input  gdad_pkg::gdad_status_t status,
  output gdad_pkg::gdad_cmd_t    cmd
);
  import gdad_pkg::*;

  gdad_state_t       state;
  gdad_state_t       state_next;
  logic [STEP_W-1:0] step;
  logic [STEP_W-1:0] step_next;
  logic              out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= '0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    cmd.op     = CMD_NONE;
    cmd.step   = step;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.op     = CMD_LOAD;
          step_next  = '0;
          state_next = ST_REDUCE;
        end
      end
      ST_REDUCE: begin
        cmd.op = CMD_REDUCE;
        if (step == STEP_W'(REDUCE_STEPS - 1)) begin
          state_next = ST_CLAMP;
        end else begin
          step_next = step + STEP_W'(1);
        end
      end
      ST_CLAMP: begin
        cmd.op     = CMD_CLAMP;
        state_next = ST_YEAR;
      end
      ST_YEAR: begin
        if (status.n_ge_year) begin
          cmd.op = CMD_YEAR;
        end else begin
          state_next = ST_DAY;
        end
      end
      ST_DAY: begin
        if (!status.n_zero) begin
          cmd.op = CMD_DAY;
        end else begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid || !out_stall) begin
          cmd.op     = CMD_OUT;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
    out_valid_next = (out_valid && out_stall) || (cmd.op == CMD_OUT);
  end

endmodule

// ----- rtl/gdad_checker.sv -----
// port-level checks for the date adder, bound to the top level
module gdad_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [4:0]  end_day,
  input logic [3:0]  end_month,
  input logic [13:0] end_year
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(end_day) && $stable(end_month)
      && $stable(end_year))
    else $error("result changed while stalled");

  // one item at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("new item taken while busy");

  // results always have a month from 1 to 12 and a day of at least 1
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> end_month >= 4'd1 && end_month <= 4'd12 && end_day >= 5'd1)
    else $error("result date out of range");

  a_reset_clear: assert property (@(posedge clk)
    rst |=> !out_valid && !in_stall)
    else $error("reset did not clear the handshake");

endmodule

bind gregorian_date_add_days gdad_checker u_gdad_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .end_day   (end_day),
  .end_month (end_month),
  .end_year  (end_year)
);

// ----- dv/gregorian_date_add_days_tb.sv -----
// testbench for the gregorian date adder: directed dates, random traffic and backpressure
`timescale 1ns / 1ps

module gregorian_date_add_days_tb;

  localparam int unsigned DAYS_LEAP_YEAR   = 366;
  localparam int unsigned DAYS_COMMON_YEAR = 365;
  localparam int unsigned FEB_LEAP_DAYS    = 29;
  localparam int unsigned FEB_COMMON_DAYS  = 28;
  localparam int unsigned LAST_MONTH       = 12;
  localparam int          DRAIN_CYCLES     = 600;
  localparam int          LONG_HOLD_CYCLES = 1500;

  typedef struct packed {
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
  } date_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [4:0]  start_day = '0;
  logic [3:0]  start_month = '0;
  logic [13:0] start_year = '0;
  logic [15:0] days_to_add = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [4:0]  end_day;
  logic [3:0]  end_month;
  logic [13:0] end_year;

  date_t pending_dates[$];
  int    items_sent = 0;
  int    results_checked = 0;
  int    error_count = 0;
  int    tx_idle_pct = 0;
  int    rx_idle_pct = 0;
  int    hold_requests = 0;
  int    hold_seen = 0;
  int    hold_left = 0;

  gregorian_date_add_days DUT (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .start_day   (start_day),
    .start_month (start_month),
    .start_year  (start_year),
    .days_to_add (days_to_add),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .end_day     (end_day),
    .end_month   (end_month),
    .end_year    (end_year)
  );

  always #5 clk = ~clk;

  function automatic bit is_leap_year(input int unsigned y);
    return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
  endfunction

  function automatic int unsigned month_days(input int unsigned m, input int unsigned y);
    case (m)
      2:           return is_leap_year(y) ? FEB_LEAP_DAYS : FEB_COMMON_DAYS;
      4, 6, 9, 11: return 30;
      default:     return 31;
    endcase
  endfunction

  // date reached after cnt days, with out-of-range day and month clamped first
  function automatic date_t advance_date(input logic [4:0] sd, input logic [3:0] sm,
                                         input logic [13:0] sy, input logic [15:0] cnt);
    int unsigned d, m, y, left;
    date_t res;
    d = 32'(sd);
    m = 32'(sm);
    y = 32'(sy);
    left = 32'(cnt);
    if (m == 0) m = 1;
    if (m > LAST_MONTH) m = LAST_MONTH;
    if (d == 0) d = 1;
    if (d > month_days(m, y)) d = month_days(m, y);
    // whole-year jumps, charging a leap day only when feb 29 is crossed
    while (left >= DAYS_LEAP_YEAR) begin
      if (m <= 2) begin
        if (is_leap_year(y)) begin
          left -= DAYS_LEAP_YEAR;
          if (m == 2 && d == FEB_LEAP_DAYS) begin
            m = 3;
            d = 1;
          end
        end else begin
          left -= DAYS_COMMON_YEAR;
        end
      end else begin
        left -= is_leap_year(y + 1) ? DAYS_LEAP_YEAR : DAYS_COMMON_YEAR;
      end
      y++;
    end
    while (left > 0) begin
      left--;
      d++;
      if (d > month_days(m, y)) begin
        d = 1;
        m++;
        if (m > LAST_MONTH) begin
          m = 1;
          y++;
        end
      end
    end
    res.day   = d[4:0];
    res.month = m[3:0];
    res.year  = y[13:0];
    return res;
  endfunction

  // called at a falling edge; returns at the falling edge after the item is taken
  task automatic send_date(input logic [4:0] d, input logic [3:0] m, input logic [13:0] y,
                           input logic [15:0] n);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    start_day   <= d;
    start_month <= m;
    start_year  <= y;
    days_to_add <= n;
    do @(posedge clk); while (in_stall);
    pending_dates.push_back(advance_date(d, m, y, n));
    items_sent++;
    @(negedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_dates.size() != 0) @(negedge clk);
  endtask

  task automatic run_random(input int count);
    logic [4:0]  d;
    logic [3:0]  m;
    logic [13:0] y;
    logic [15:0] n;
    int unsigned pick;
    repeat (count) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        // feb 29 in leap years, feb 28 otherwise
        y = 14'(4 * $urandom_range(2499));
        m = 4'd2;
        d = is_leap_year(32'(y)) ? 5'(FEB_LEAP_DAYS) : 5'(FEB_COMMON_DAYS);
      end else if (pick < 85) begin
        y = 14'($urandom_range(9999));
        m = 4'($urandom_range(12, 1));
        d = 5'($urandom_range(month_days(32'(m), 32'(y)), 1));
      end else begin
        d = 5'($urandom_range(31));
        m = 4'($urandom_range(15));
        y = 14'($urandom_range(16383));
      end
      // mostly short counts to keep the run fast, some across the full range
      pick = $urandom_range(9);
      if (pick == 0)     n = 16'($urandom_range(370, 360));
      else if (pick < 5) n = 16'($urandom_range(800));
      else if (pick < 8) n = 16'($urandom_range(4000));
      else               n = 16'($urandom_range(65535));
      send_date(d, m, y, n);
    end
  endtask

  task automatic test_directed_dates();
    tx_idle_pct = 13;
    rx_idle_pct = 62;
    send_date(5'd1, 4'd1, 14'd0, 16'd0);
    send_date(5'd31, 4'd12, 14'd9999, 16'd65535);
    // feb 29 start, with and without the year jump
    send_date(5'd29, 4'd2, 14'd2000, 16'd366);
    send_date(5'd29, 4'd2, 14'd2000, 16'd365);
    send_date(5'd29, 4'd2, 14'd1996, 16'd1461);
    // day past the end of its month
    send_date(5'd29, 4'd2, 14'd1900, 16'd1);
    send_date(5'd31, 4'd4, 14'd2023, 16'd1);
    send_date(5'd30, 4'd2, 14'd2000, 16'd0);
    // zero day and month, months past december
    send_date(5'd0, 4'd0, 14'd2023, 16'd0);
    send_date(5'd31, 4'd13, 14'd2023, 16'd1);
    send_date(5'd0, 4'd15, 14'd16383, 16'd0);
    // year above 9999 with the end year wrapping, then single-day steps
    send_date(5'd31, 4'd15, 14'd16383, 16'd65535);
    send_date(5'd1, 4'd1, 14'd8192, 16'd1);
    send_date(5'd28, 4'd2, 14'd2024, 16'd1);
    send_date(5'd31, 4'd12, 14'd1999, 16'd1);
    // century rules on the year jump and on day steps
    send_date(5'd1, 4'd3, 14'd2099, 16'd366);
    send_date(5'd1, 4'd3, 14'd2399, 16'd366);
    send_date(5'd15, 4'd1, 14'd2400, 16'd365);
    send_date(5'd15, 4'd1, 14'd2400, 16'd366);
    send_date(5'd31, 4'd1, 14'd2100, 16'd29);
    send_date(5'd10, 4'd6, 14'd5000, 16'd32768);
  endtask

  task automatic test_random_slow_receiver();
    tx_idle_pct = 13;
    rx_idle_pct = 62;
    run_random(360);
  endtask

  task automatic test_random_slow_sender();
    tx_idle_pct = 62;
    rx_idle_pct = 13;
    run_random(360);
  endtask

  task automatic test_random_no_idle();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    run_random(340);
  endtask

  // receiver holds off long enough that the output register and the input both back up
  task automatic test_output_backpressure();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    hold_requests++;
    repeat (6) send_date(5'($urandom_range(28, 1)), 4'($urandom_range(12, 1)),
                         14'($urandom_range(9999)), 16'($urandom_range(30)));
    drain_results();
  endtask

  always @(negedge clk) begin : drive_out_stall
    if (hold_seen != hold_requests) begin
      hold_seen = hold_requests;
      hold_left = LONG_HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  always @(posedge clk) begin : check_dates
    date_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_dates.size() == 0) begin
        $error("unexpected result %0d-%0d-%0d with nothing pending",
               end_year, end_month, end_day);
        error_count++;
      end else begin
        want = pending_dates.pop_front();
        results_checked++;
        if (end_day !== want.day) begin
          $error("end_day mismatch: expected %0d, got %0d", want.day, end_day);
          error_count++;
        end
        if (end_month !== want.month) begin
          $error("end_month mismatch: expected %0d, got %0d", want.month, end_month);
          error_count++;
        end
        if (end_year !== want.year) begin
          $error("end_year mismatch: expected %0d, got %0d", want.year, end_year);
          error_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed_dates();
    test_random_slow_receiver();
    test_output_backpressure();
    test_random_slow_sender();
    test_random_no_idle();
    drain_results();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (pending_dates.size() != 0) begin
      $error("%0d results never arrived", pending_dates.size());
      error_count++;
    end
    $display("covered %0d dates: edge cases, feb 29 jumps, clamped fields, wrapped years,",
             items_sent);
    $display("random traffic under idling and a long output hold; %0d results checked",
             results_checked);
    if (error_count == 0) begin
      $display("gregorian_date_add_days_tb: done, clean");
    end else begin
      $display("gregorian_date_add_days_tb: done, errors");
    end
    $finish;
  end

  initial begin
    #50_000_000;
    $display("timed out with %0d results outstanding", pending_dates.size());
    $display("gregorian_date_add_days_tb: done, errors");
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/gdad_pkg.sv
rtl/gdad_datapath.sv
rtl/gdad_ctrl.sv
rtl/gregorian_date_add_days.sv
rtl/gdad_checker.sv
dv/gregorian_date_add_days_tb.sv
